/* hdl/e2q_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package e2q_pkg;

   localparam int ANGLE_BITS_DEF = 16;
   localparam int OUT_BITS_DEF = 16;
   localparam int SINCOS_STAGES_DEF = 16;

   // CORDIC datapath: Q30 values, one guard bit plus sign
   localparam int DW = 33;
   localparam int ZW = 34;
   localparam int FRAC = 30;
   localparam logic signed [DW-1:0] GAIN_Q30 = 33'sd652032874;

   typedef struct packed {
      logic [ANGLE_BITS_DEF-1:0] roll_angle;
      logic [ANGLE_BITS_DEF-1:0] pitch_angle;
      logic [ANGLE_BITS_DEF-1:0] yaw_angle;
   } req_type;

   typedef struct packed {
      logic [OUT_BITS_DEF-1:0] quat_w;
      logic [OUT_BITS_DEF-1:0] quat_x;
      logic [OUT_BITS_DEF-1:0] quat_y;
      logic [OUT_BITS_DEF-1:0] quat_z;
   } rsp_type;

   // arctangent table, 2*pi == 2^32
   function automatic logic signed [ZW-1:0] atan_val(input int i);
      logic [31:0] t;
      case (i)
         0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
         3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
         6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
         9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
         12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
         15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
         18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
         21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
         24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
         27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
         30: t = 32'h00000001;
         default: t = 32'h0;
      endcase
      atan_val = $signed({2'b00, t});
   endfunction

endpackage
`default_nettype wire

/* hdl/e2q_cordic.sv */
`timescale 1ns / 1ps
`default_nettype none
// Pipelined CORDIC: one rotation stage per register, gives cos/sin of half angle.
module e2q_cordic #(
   parameter int ANGLE_BITS = e2q_pkg::ANGLE_BITS_DEF,
   parameter int SINCOS_STAGES = e2q_pkg::SINCOS_STAGES_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             en,
   input  wire logic [ANGLE_BITS-1:0]            angle,
   output logic signed [e2q_pkg::DW-1:0]         cos_q,
   output logic signed [e2q_pkg::DW-1:0]         sin_q
);
   localparam int DW = e2q_pkg::DW;
   localparam int ZW = e2q_pkg::ZW;
   localparam int N = (SINCOS_STAGES < 32) ? SINCOS_STAGES : 32;

   logic signed [DW-1:0] x_ff [1:N];
   logic signed [DW-1:0] y_ff [1:N];
   logic signed [ZW-1:0] z_ff [1:N];
   logic signed [ZW-1:0] z0;

   // half angle in 2^32 units per turn
   always_comb begin
      if (ANGLE_BITS <= 31)
         z0 = ZW'($signed(angle)) <<< (31 - ANGLE_BITS);
      else
         z0 = ZW'($signed(angle) >>> (ANGLE_BITS - 31));
   end

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic signed [DW-1:0] x_cur, y_cur;
      logic signed [ZW-1:0] z_cur;
      logic signed [DW-1:0] x_in, y_in;
      logic signed [ZW-1:0] z_in;
      logic signed [DW-1:0] xs, ys;
      // first stage starts from the gain and the fresh half angle
      if (i == 0) begin : g_first
         assign x_cur = e2q_pkg::GAIN_Q30;
         assign y_cur = '0;
         assign z_cur = z0;
      end else begin : g_next
         assign x_cur = x_ff[i];
         assign y_cur = y_ff[i];
         assign z_cur = z_ff[i];
      end
      always_comb begin
         xs = x_cur >>> i;
         ys = y_cur >>> i;
         if (!z_cur[ZW-1]) begin
            x_in = x_cur - ys;
            y_in = y_cur + xs;
            z_in = z_cur - e2q_pkg::atan_val(i);
         end else begin
            x_in = x_cur + ys;
            y_in = y_cur - xs;
            z_in = z_cur + e2q_pkg::atan_val(i);
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1] <= x_in;
            y_ff[i+1] <= y_in;
            z_ff[i+1] <= z_in;
         end
      end
   end

   assign cos_q = x_ff[N];
   assign sin_q = y_ff[N];
endmodule
`default_nettype wire

/* hdl/e2q_qmul.sv */
`timescale 1ns / 1ps
`default_nettype none
// Hamilton product (qx*qy)*qz in Q30, two multiply stages, then round/saturate.
module e2q_qmul #(
   parameter int OUT_BITS = e2q_pkg::OUT_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic signed [e2q_pkg::DW-1:0] cx, sx, cy, sy, cz, sz,
   output logic [4*OUT_BITS-1:0]             quat
);
   localparam int DW = e2q_pkg::DW;
   localparam int PW = 2 * DW;
   localparam int FRAC = e2q_pkg::FRAC;
   localparam int SH = FRAC + 1 - OUT_BITS;
   localparam int SW = DW + 2;

   function automatic logic signed [DW-1:0] mulq(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
      logic signed [PW-1:0] p;
      p = PW'(a) * PW'(b) + (PW'(1) <<< (FRAC - 1));
      mulq = DW'(p >>> FRAC);
   endfunction

   function automatic logic [OUT_BITS-1:0] to_out(input logic signed [SW-1:0] v);
      logic signed [SW+OUT_BITS:0] t, hi, lo;
      t = (SW + OUT_BITS + 1)'(v);
      if (SH > 0)
         t = (t + ((SW + OUT_BITS + 1)'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> (SH > 0 ? SH : 0);
      else if (SH < 0)
         t = t <<< (SH < 0 ? -SH : 0);
      hi = ((SW + OUT_BITS + 1)'(1) <<< (OUT_BITS - 1)) - 1;
      lo = -((SW + OUT_BITS + 1)'(1) <<< (OUT_BITS - 1));
      if (t > hi) t = hi;
      if (t < lo) t = lo;
      to_out = OUT_BITS'(t);
   endfunction

   // stage 1: qx*qy, carry qz along
   logic signed [DW-1:0] tw_ff, tx_ff, ty_ff, tz_ff, cz_ff, sz_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         tw_ff <= mulq(cx, cy);
         tx_ff <= mulq(sx, cy);
         ty_ff <= mulq(cx, sy);
         tz_ff <= mulq(sx, sy);
         cz_ff <= cz;
         sz_ff <= sz;
      end
   end

   // stage 2: products with qz
   logic signed [DW-1:0] p_ff [8];
   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= mulq(tw_ff, cz_ff);
         p_ff[1] <= mulq(tz_ff, sz_ff);
         p_ff[2] <= mulq(tx_ff, cz_ff);
         p_ff[3] <= mulq(ty_ff, sz_ff);
         p_ff[4] <= mulq(ty_ff, cz_ff);
         p_ff[5] <= mulq(tx_ff, sz_ff);
         p_ff[6] <= mulq(tz_ff, cz_ff);
         p_ff[7] <= mulq(tw_ff, sz_ff);
      end
   end

   // stage 3: sums, round and saturate
   logic [4*OUT_BITS-1:0] q_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= {to_out(SW'(p_ff[0]) - SW'(p_ff[1])),
                  to_out(SW'(p_ff[2]) + SW'(p_ff[3])),
                  to_out(SW'(p_ff[4]) - SW'(p_ff[5])),
                  to_out(SW'(p_ff[6]) + SW'(p_ff[7]))};
      end
   end
   assign quat = q_ff;
endmodule
`default_nettype wire

/* hdl/euler_to_quaternion.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Payload            Handshake
// req_      in         roll/pitch/yaw     req_valid / req_stall
// rsp_      out        quat_w/x/y/z       rsp_valid / rsp_stall
// The pipeline is the CORDIC stages, two multiply stages and one
// round/saturate stage; one request per cycle sustained unless a stall holds the output.
// A stall at the output freezes the whole pipeline; a bubble never blocks.
// Reset clears the valid bits only.
module euler_to_quaternion #(
   parameter int SINCOS_STAGES = e2q_pkg::SINCOS_STAGES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire e2q_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output e2q_pkg::rsp_type      rsp_data
);
   localparam int N = (SINCOS_STAGES < 32) ? SINCOS_STAGES : 32;
   localparam int LAT = N + 3;
   localparam int DW = e2q_pkg::DW;

   logic en;
   logic [LAT-1:0] vld_ff, vld_in;
   logic signed [DW-1:0] cx, sx, cy, sy, cz, sz;

   // pipeline advances unless the output holds a result that is stalled
   assign en = !(vld_ff[LAT-1] && rsp_stall);
   assign req_stall = !en;

   always_comb begin
      vld_in = {vld_ff[LAT-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset)
         vld_ff <= '0;
      else if (en)
         vld_ff <= vld_in;
   end

   e2q_cordic #(.ANGLE_BITS(e2q_pkg::ANGLE_BITS_DEF), .SINCOS_STAGES(SINCOS_STAGES)) u_cx (
      .clock(clock), .en(en), .angle(req_data.roll_angle), .cos_q(cx), .sin_q(sx));
   e2q_cordic #(.ANGLE_BITS(e2q_pkg::ANGLE_BITS_DEF), .SINCOS_STAGES(SINCOS_STAGES)) u_cy (
      .clock(clock), .en(en), .angle(req_data.pitch_angle), .cos_q(cy), .sin_q(sy));
   e2q_cordic #(.ANGLE_BITS(e2q_pkg::ANGLE_BITS_DEF), .SINCOS_STAGES(SINCOS_STAGES)) u_cz (
      .clock(clock), .en(en), .angle(req_data.yaw_angle), .cos_q(cz), .sin_q(sz));

   e2q_qmul #(.OUT_BITS(e2q_pkg::OUT_BITS_DEF)) u_qmul (
      .clock(clock), .en(en),
      .cx(cx), .sx(sx), .cy(cy), .sy(sy), .cz(cz), .sz(sz),
      .quat(rsp_data));

   assign rsp_valid = vld_ff[LAT-1];
endmodule
`default_nettype wire
